/* design/fcba_pkg.sv */
// ----------------------------------------------------------------------------
// fcba_pkg
// Types, register codes and key helpers shared by the bin assigner modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fcba_pkg;

  localparam int MAX_BINS_DEF = 16;

  localparam int CODE_W = 4;
  localparam int BIN_W  = 5;
  localparam int MODE_W = 2;
  localparam int CFG_W  = 5;   // widest register (bucket_count)
  localparam int CFG_IDX_W = 1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SORT_MODE    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BUCKET_COUNT = 1'd1;

  // sort modes
  localparam logic [MODE_W-1:0] MODE_COLOR = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SIZE  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_BOTH  = 2'd2;

  localparam logic [MODE_W-1:0] SORT_MODE_RST    = MODE_COLOR;
  localparam logic [CFG_W-1:0]  BUCKET_COUNT_RST = 5'd4;

  localparam logic [BIN_W-1:0] REST_BIN  = 5'd1;
  localparam int               FIRST_BIN = 2;

  // special codes
  localparam logic [CODE_W-1:0] COLOR_MULTI    = 4'd1;
  localparam logic [CODE_W-1:0] COLOR_LAST_BAD = 4'd1;  // colors 0..1 not stored
  localparam logic [CODE_W-1:0] SIZE_LAST_BAD  = 4'd2;  // sizes 0..2 not stored

  typedef struct packed {
    logic [CODE_W-1:0] color_code;
    logic [CODE_W-1:0] size_code;
  } in_item_t;

  typedef struct packed {
    logic [BIN_W-1:0] bin_number;
    logic             newly_assigned;
  } out_item_t;

  typedef struct packed {
    logic [CODE_W-1:0] color;
    logic [CODE_W-1:0] size;
  } entry_t;

  function automatic logic key_match(input logic [MODE_W-1:0] mode,
                                     input entry_t e, input in_item_t it);
    logic hit;
    case (mode)
      MODE_COLOR: hit = (e.color == it.color_code);
      MODE_SIZE:  hit = (e.size == it.size_code);
      default:    hit = (e.color == it.color_code) && (e.size == it.size_code);
    endcase
    return hit;
  endfunction

  // mode 3 behaves as both-mode; no-object color is allowed in both-mode
  function automatic logic key_excluded(input logic [MODE_W-1:0] mode,
                                        input in_item_t it);
    logic excl;
    case (mode)
      MODE_COLOR: excl = (it.color_code <= COLOR_LAST_BAD);
      MODE_SIZE:  excl = (it.size_code <= SIZE_LAST_BAD);
      default:    excl = (it.size_code <= SIZE_LAST_BAD) ||
                         (it.color_code == COLOR_MULTI);
    endcase
    return excl;
  endfunction

endpackage

`default_nettype wire

/* design/fcba_table.sv */
// ----------------------------------------------------------------------------
// fcba_table
// Class table storage: one write port, one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fcba_table #(
  parameter int DEPTH = fcba_pkg::MAX_BINS_DEF - 1,
  parameter int IDX_W = 4
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [IDX_W-1:0] wr_idx,
  input  wire fcba_pkg::entry_t wr_data,
  input  wire logic             rd_en,
  input  wire logic [IDX_W-1:0] rd_idx,
  output fcba_pkg::entry_t      rd_data
);

  fcba_pkg::entry_t mem [DEPTH];
  fcba_pkg::entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_idx];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

/* design/fcba_seq.sv */
// ----------------------------------------------------------------------------
// fcba_seq
// Sequencer: walks the table one entry a cycle through a shared key compare,
// stops at a match, else appends a new class or falls back to the rest bin.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fcba_seq #(
  parameter int MAX_BINS = fcba_pkg::MAX_BINS_DEF,
  parameter int DEPTH    = MAX_BINS - 1,
  parameter int IDX_W    = 4,
  parameter int CNT_W    = 4
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic [fcba_pkg::MODE_W-1:0]   sort_mode,
  input  wire logic [fcba_pkg::CFG_W-1:0]    bucket_count,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire fcba_pkg::in_item_t            in_data,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output fcba_pkg::out_item_t                out_data,
  output logic                               tbl_wr_en,
  output logic [IDX_W-1:0]                   tbl_wr_idx,
  output fcba_pkg::entry_t                   tbl_wr_data,
  output logic                               tbl_rd_en,
  output logic [IDX_W-1:0]                   tbl_rd_idx,
  input  wire fcba_pkg::entry_t              tbl_rd_data
);

  // wide enough for bucket_count, MAX_BINS and index + 2
  localparam int LIM_W = ($clog2(MAX_BINS + 2) > fcba_pkg::CFG_W) ?
                         $clog2(MAX_BINS + 2) : fcba_pkg::CFG_W;
  localparam logic [LIM_W-1:0] MAX_LIM = LIM_W'(MAX_BINS);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_HOLD = 2'd2;

  logic [1:0]          state_r, state_nxt;
  logic [CNT_W-1:0]    filled_r, filled_nxt;
  logic [CNT_W-1:0]    rd_cnt_r, rd_cnt_nxt;   // next entry to read
  logic                cmp_vld_r, cmp_vld_nxt; // read data belongs to rd_cnt_r - 1
  fcba_pkg::in_item_t  item_r, item_nxt;
  logic                out_valid_r, out_valid_nxt;
  fcba_pkg::out_item_t out_data_r, out_data_nxt;

  logic [LIM_W-1:0] bc_ext, limit, fill_ext;
  logic             hit, scan_end, can_add;

  assign bc_ext   = LIM_W'(bucket_count);
  assign limit    = (bc_ext > MAX_LIM) ? MAX_LIM : bc_ext;
  assign fill_ext = LIM_W'(filled_r);
  assign hit      = cmp_vld_r && fcba_pkg::key_match(sort_mode, tbl_rd_data, item_r);
  assign scan_end = (rd_cnt_r == filled_r);
  assign can_add  = (fill_ext + LIM_W'(1) < limit) &&
                    !fcba_pkg::key_excluded(sort_mode, item_r);

  always_comb begin
    state_nxt     = state_r;
    filled_nxt    = filled_r;
    rd_cnt_nxt    = rd_cnt_r;
    cmp_vld_nxt   = cmp_vld_r;
    item_nxt      = item_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    tbl_wr_en     = 1'b0;
    tbl_rd_en     = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          item_nxt    = in_data;
          rd_cnt_nxt  = '0;
          cmp_vld_nxt = 1'b0;
          state_nxt   = S_SCAN;
        end
      end
      S_SCAN: begin
        if (hit) begin
          // entry rd_cnt_r - 1 matched: bin = index + 2
          out_data_nxt.bin_number     =
            fcba_pkg::BIN_W'(LIM_W'(rd_cnt_r) + LIM_W'(fcba_pkg::FIRST_BIN - 1));
          out_data_nxt.newly_assigned = 1'b0;
          out_valid_nxt = 1'b1;
          state_nxt     = S_HOLD;
        end else if (!scan_end) begin
          tbl_rd_en   = 1'b1;
          cmp_vld_nxt = 1'b1;
          rd_cnt_nxt  = rd_cnt_r + CNT_W'(1);
        end else begin
          if (can_add) begin
            tbl_wr_en  = 1'b1;
            filled_nxt = filled_r + CNT_W'(1);
            out_data_nxt.bin_number =
              fcba_pkg::BIN_W'(fill_ext + LIM_W'(fcba_pkg::FIRST_BIN));
            out_data_nxt.newly_assigned = 1'b1;
          end else begin
            out_data_nxt.bin_number     = fcba_pkg::REST_BIN;
            out_data_nxt.newly_assigned = 1'b0;
          end
          out_valid_nxt = 1'b1;
          state_nxt     = S_HOLD;
        end
      end
      S_HOLD: begin
        if (out_ready) begin
          out_valid_nxt = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      filled_r    <= '0;
      rd_cnt_r    <= '0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      filled_r    <= filled_nxt;
      rd_cnt_r    <= rd_cnt_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_ready    = (state_r == S_IDLE);
  assign out_valid   = out_valid_r;
  assign out_data    = out_data_r;
  assign tbl_rd_idx  = rd_cnt_r[IDX_W-1:0];
  assign tbl_wr_idx  = filled_r[IDX_W-1:0];
  assign tbl_wr_data = '{color: item_r.color_code, size: item_r.size_code};

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    LIM_W'(filled_r) <= LIM_W'(DEPTH))
    else $error("table fill count beyond depth");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rd_cnt_r <= filled_r)
    else $error("scan pointer past filled entries");

  a_ready_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid_r))
    else $error("input ready while a result is pending");

  a_new_entry: assert property (@(posedge clk) disable iff (!rst_n)
    tbl_wr_en |=> out_valid_r && out_data_r.newly_assigned &&
                  filled_r == $past(filled_r) + CNT_W'(1))
    else $error("table write without a new-entry result");

endmodule

`default_nettype wire

/* design/first_come_bin_assigner.sv */
// ----------------------------------------------------------------------------
// first_come_bin_assigner
// Assigns each classified part a bin, adding new classes in arrival order.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : valid/ready channel, one item = color code + size code.
//   out_* : valid/ready channel, exactly one result item per input item
//           (bin number, new-entry flag).
//   cfg_* : write-only registers, 0 = sort_mode, 1 = bucket_count; write
//           only while no item is in flight.
// Operation: an item walks the class table one entry per cycle through a single
//   key comparator. One item is in flight at a time.
// Reset: synchronous rst_n empties the table (fill count to zero) and loads
//   sort_mode 0, bucket_count 4. Table contents need no clearing.
// Stall: the result is held in the output register until out_ready; no new
//   item is taken until it leaves.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module first_come_bin_assigner #(
  parameter int MAX_BINS = fcba_pkg::MAX_BINS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire fcba_pkg::in_item_t            in_data,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output fcba_pkg::out_item_t                out_data,
  input  wire logic                          cfg_we,
  input  wire logic [fcba_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  wire logic [fcba_pkg::CFG_W-1:0]    cfg_wdata
);

  localparam int DEPTH = MAX_BINS - 1;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [fcba_pkg::MODE_W-1:0] sort_mode_r;
  logic [fcba_pkg::CFG_W-1:0]  bucket_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sort_mode_r    <= fcba_pkg::SORT_MODE_RST;
      bucket_count_r <= fcba_pkg::BUCKET_COUNT_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        fcba_pkg::REG_SORT_MODE:    sort_mode_r    <= cfg_wdata[fcba_pkg::MODE_W-1:0];
        fcba_pkg::REG_BUCKET_COUNT: bucket_count_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic             tbl_wr_en, tbl_rd_en;
  logic [IDX_W-1:0] tbl_wr_idx, tbl_rd_idx;
  fcba_pkg::entry_t tbl_wr_data, tbl_rd_data;

  fcba_seq #(
    .MAX_BINS (MAX_BINS),
    .DEPTH    (DEPTH),
    .IDX_W    (IDX_W),
    .CNT_W    (CNT_W)
  ) u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .sort_mode    (sort_mode_r),
    .bucket_count (bucket_count_r),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data),
    .tbl_wr_en    (tbl_wr_en),
    .tbl_wr_idx   (tbl_wr_idx),
    .tbl_wr_data  (tbl_wr_data),
    .tbl_rd_en    (tbl_rd_en),
    .tbl_rd_idx   (tbl_rd_idx),
    .tbl_rd_data  (tbl_rd_data)
  );

  fcba_table #(
    .DEPTH (DEPTH),
    .IDX_W (IDX_W)
  ) u_table (
    .clk     (clk),
    .wr_en   (tbl_wr_en),
    .wr_idx  (tbl_wr_idx),
    .wr_data (tbl_wr_data),
    .rd_en   (tbl_rd_en),
    .rd_idx  (tbl_rd_idx),
    .rd_data (tbl_rd_data)
  );

endmodule

`default_nettype wire
